FILE: src/atc_pkg.sv
// Package for the audio transition crossfader: constants, stage types and the fade table.
package atc_pkg;

    // Fade length in frames and the ceiling on the mute gap.
    localparam int FADE_FRAMES     = 256;
    localparam int MAX_MUTE_FRAMES = 1023;

    // Field and state widths.
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int MUTE_W    = 10;
    localparam int POS_W     = 11;
    localparam int TBL_IDX_W = (FADE_FRAMES > 1) ? $clog2(FADE_FRAMES) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = MUTE_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_FRAMES = 1'b1;

    // Unity weight in unsigned Q1.15.
    localparam logic [WEIGHT_W-1:0] W_ONE = 16'h8000;

    // Fixed-point constants used only while the table is built.
    localparam logic [63:0] Q30_ONE   = 64'd1073741824;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] FADE_SPAN = 64'(2 * FADE_FRAMES);

    typedef logic [WEIGHT_W-1:0] fade_table_t [FADE_FRAMES];

    // Request after the weight lookup, waiting for the blend stage.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] old_sample;
        logic signed [SAMPLE_W-1:0] new_sample;
        logic [WEIGHT_W-1:0]        w_out;
        logic [WEIGHT_W-1:0]        w_in;
        logic                       done;
    } blend_req_t;

    // Cosine in Q30 for an argument in [0, pi/2], Taylor series to x^12.
    function automatic logic [63:0] cos_q30(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] q;
        x2 = (x * x) >> 30;
        p  = Q30_ONE;
        q  = ((x2 * p) >> 30) / 132;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q  = ((x2 * p) >> 30) / 90;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q  = ((x2 * p) >> 30) / 56;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q  = ((x2 * p) >> 30) / 30;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q  = ((x2 * p) >> 30) / 12;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q  = ((x2 * p) >> 30) / 2;
        p  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        return p;
    endfunction

    // Raised-cosine fade-out weights, sampled at the middle of each frame.
    function automatic fade_table_t build_fade_table();
        fade_table_t t;
        logic [63:0] odd;
        logic [63:0] w;
        for (int i = 0; i < FADE_FRAMES; i++)
        begin
            odd = 64'(2 * i + 1);
            if (odd <= 64'(FADE_FRAMES))
            begin
                w = (Q30_ONE + cos_q30((odd * PI_Q30) / FADE_SPAN)) / 2;
            end
            else
            begin
                w = (Q30_ONE - cos_q30(((FADE_SPAN - odd) * PI_Q30) / FADE_SPAN)) / 2;
            end
            t[i] = WEIGHT_W'((w + 64'd16384) >> 15);
        end
        return t;
    endfunction

    localparam fade_table_t FADE_TABLE = build_fade_table();

endpackage

FILE: src/audio_transition_crossfader.sv
// Top level of the audio transition crossfader: fade state, weight lookup and handshakes.
// An accepted request passes through the lookup-stage register and then the result register to the output.
// One request per cycle while the output is not stalled; the weight lookup and the blend multiplies are pipelined.
// A stalled output holds its result while one more request waits in the lookup stage.
// Reset clears the configuration registers, the fade position, the finished flag and both valid flags.
module audio_transition_crossfader
    import atc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic signed [SAMPLE_W-1:0]  old_sample,
    input  logic signed [SAMPLE_W-1:0]  new_sample,
    input  logic                        frame_end,
    input  logic                        buffer_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  out_sample,
    output logic                        transition_done
);

    localparam logic [POS_W-1:0]  FADE_N   = POS_W'(FADE_FRAMES);
    localparam logic [MUTE_W-1:0] MUTE_MAX = MUTE_W'(MAX_MUTE_FRAMES);

    logic              gap_mode_reg;
    logic [MUTE_W-1:0] mute_frames_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              finished_reg;
    logic              finished_next;
    logic              lk_valid_reg;
    logic              out_valid_reg;
    blend_req_t        lk_reg;
    blend_req_t        lk_next;

    logic              in_accept;
    logic              lk_move;
    logic              out_move;

    logic [MUTE_W-1:0]    mute_len;
    logic [POS_W-1:0]     fade_in_start;
    logic [POS_W-1:0]     fade_total;
    logic [POS_W-1:0]     tbl_pos;
    logic [TBL_IDX_W-1:0] tbl_idx;
    logic [WEIGHT_W-1:0]  tbl_w;

    // Pipeline flow: the result register frees first, then the lookup stage.
    assign out_move  = !out_valid_reg || !out_stall;
    assign lk_move   = !lk_valid_reg || out_move;
    assign in_stall  = !lk_move;
    assign in_accept = in_valid && lk_move;
    assign out_valid = out_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_mode_reg    <= 1'b0;
            mute_frames_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAP_MODE:    gap_mode_reg    <= cfg_data[0];
                REG_MUTE_FRAMES: mute_frames_reg <= cfg_data[MUTE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Transition length and the frame where the fade-in starts.
    always_comb
    begin
        mute_len      = (mute_frames_reg > MUTE_MAX) ? MUTE_MAX : mute_frames_reg;
        fade_in_start = FADE_N + POS_W'(mute_len);
        fade_total    = gap_mode_reg ? (fade_in_start + FADE_N) : FADE_N;
        tbl_pos       = (gap_mode_reg && (pos_reg >= fade_in_start))
                        ? (pos_reg - fade_in_start) : pos_reg;
        tbl_idx       = tbl_pos[TBL_IDX_W-1:0];
        tbl_w         = FADE_TABLE[tbl_idx];
    end

    // Weight selection and the next fade state for the request on the input.
    always_comb
    begin
        pos_next           = pos_reg;
        finished_next      = finished_reg;
        lk_next.old_sample = old_sample;
        lk_next.new_sample = new_sample;
        lk_next.w_out      = '0;
        lk_next.w_in       = W_ONE;
        lk_next.done       = 1'b0;
        if (req_type)
        begin
            if (pos_reg < fade_total)
            begin
                if (!gap_mode_reg)
                begin
                    lk_next.w_out = tbl_w;
                    lk_next.w_in  = W_ONE - tbl_w;
                end
                else if (pos_reg < FADE_N)
                begin
                    lk_next.w_out = tbl_w;
                    lk_next.w_in  = '0;
                end
                else if (pos_reg >= fade_in_start)
                begin
                    lk_next.w_in  = W_ONE - tbl_w;
                end
                else
                begin
                    lk_next.w_in  = '0;
                end
                if (frame_end)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                finished_next = 1'b1;
            end
            // At a buffer end once finished, report completion and rewind for the next transition.
            if (buffer_end)
            begin
                lk_next.done = finished_next;
                if (finished_next)
                begin
                    pos_next      = '0;
                    finished_next = 1'b0;
                end
            end
        end
    end

    // Fade state advances only on accepted requests.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

    // Valid flags of the lookup stage and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (lk_move)
            begin
                lk_valid_reg <= in_valid;
            end
            if (out_move)
            begin
                out_valid_reg <= lk_valid_reg;
            end
        end
    end

    // Lookup stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lk_reg <= lk_next;
        end
    end

    atc_blend u_blend
    (
        .clk             (clk),
        .load            (out_move && lk_valid_reg),
        .req             (lk_reg),
        .out_sample      (out_sample),
        .transition_done (transition_done)
    );

endmodule

FILE: src/atc_blend.sv
// Blend stage: two weighted products, rounding, saturation and the result register.
module atc_blend
    import atc_pkg::*;
(
    input  logic                       clk,
    input  logic                       load,
    input  blend_req_t                 req,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic                       transition_done
);

    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    logic signed [PROD_W-1:0]   prod_old;
    logic signed [PROD_W-1:0]   prod_new;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] sat;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       done_reg;

    // Weights are unsigned Q1.15; a zero top bit keeps them positive in the product.
    assign prod_old = req.old_sample * $signed({1'b0, req.w_out});
    assign prod_new = req.new_sample * $signed({1'b0, req.w_in});
    assign acc      = ACC_W'(prod_old) + ACC_W'(prod_new);

    // Round half up, then clamp to the Q15 range.
    always_comb
    begin
        rounded = (acc + ACC_W'(16384)) >>> 15;
        if (rounded > ACC_W'(32767))
        begin
            sat = 16'sh7FFF;
        end
        else if (rounded < -ACC_W'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = rounded[SAMPLE_W-1:0];
        end
    end

    // Result register, loaded when the output side can take a new request.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_sample_reg <= sat;
            done_reg       <= req.done;
        end
    end

    assign out_sample      = out_sample_reg;
    assign transition_done = done_reg;

endmodule
